// ===== rtl/core/vsps_pkg.sv =====
// ----------------------------------------------------------------------------
// vsps_pkg
// Shared types and constants for the video SPI segment packet synchronizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vsps_pkg;

    // Packets in one segment, and the packet that carries the segment number
    localparam int unsigned PACKETS_PER_SEG = 60;
    localparam logic [7:0]  SEG_LAST_SLOT   = 8'(PACKETS_PER_SEG - 1);
    localparam logic [7:0]  SEG_PACKET      = 8'd20;
    localparam logic [3:0]  DISCARD_NIBBLE  = 4'hF;

    // Register reset values
    localparam logic [9:0]  MAX_RESYNCS_RST = 10'd750;
    localparam logic [3:0]  MAX_SEG_NUM_RST = 4'd4;

    // Register map (word index)
    localparam logic        REG_MAX_RESYNCS = 1'b0;
    localparam logic        REG_MAX_SEG_NUM = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_RESYNC  = 3'd1,
        ST_DONE    = 3'd2,
        ST_INVALID = 3'd3,
        ST_GAVE_UP = 3'd4
    } t_status;

    // One packet header word
    typedef struct packed {
        logic [7:0] header_id_byte;
        logic [7:0] packet_number_byte;
        logic       transfer_failed;
    } t_pkt_in;

    // One result word
    typedef struct packed {
        t_status    status;
        logic [7:0] packet_slot;
        logic [3:0] seg_num;
    } t_pkt_res;

    // Configuration seen by the sync logic
    typedef struct packed {
        logic [9:0] max_resyncs;
        logic [3:0] max_seg_num;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/vsps_apb_regs.sv =====
// ----------------------------------------------------------------------------
// vsps_apb_regs
// APB register file holding the resync limit and the segment number limit.
// ----------------------------------------------------------------------------
`default_nettype none

module vsps_apb_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output vsps_pkg::t_cfg    o_cfg
);

    logic [9:0] r_max_resyncs;
    logic [3:0] r_max_seg_num;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes, word index taken from paddr[2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_resyncs <= vsps_pkg::MAX_RESYNCS_RST;
            r_max_seg_num <= vsps_pkg::MAX_SEG_NUM_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                vsps_pkg::REG_MAX_RESYNCS: r_max_resyncs <= pwdata[9:0];
                vsps_pkg::REG_MAX_SEG_NUM: r_max_seg_num <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            vsps_pkg::REG_MAX_RESYNCS: prdata = {22'd0, r_max_resyncs};
            vsps_pkg::REG_MAX_SEG_NUM: prdata = {28'd0, r_max_seg_num};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg.max_resyncs = r_max_resyncs;
    assign o_cfg.max_seg_num = r_max_seg_num;

endmodule

`default_nettype wire

// ===== rtl/core/vsps_sync_step.sv =====
// ----------------------------------------------------------------------------
// vsps_sync_step
// Sync state and the per-packet decision: store, resync, done, invalid, give up.
// ----------------------------------------------------------------------------
`default_nettype none

module vsps_sync_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire vsps_pkg::t_pkt_in i_pkt,
    input  wire vsps_pkg::t_cfg    i_cfg,
    output vsps_pkg::t_pkt_res     o_res
);

    logic [7:0] r_exp_idx,  n_exp_idx;
    logic [9:0] r_resyncs,  n_resyncs;
    logic [3:0] r_cap_seg,  n_cap_seg;

    logic       bad_pkt;
    logic [9:0] resyncs_inc;
    logic [7:0] exp_inc;
    logic [3:0] id_seg;
    logic       at_seg_pkt;
    logic       seg_bad;
    logic [3:0] cap_seg_upd;

    assign id_seg      = i_pkt.header_id_byte[7:4];
    assign bad_pkt     = i_pkt.transfer_failed || (id_seg == vsps_pkg::DISCARD_NIBBLE) ||
                         (i_pkt.packet_number_byte != r_exp_idx);
    assign resyncs_inc = r_resyncs + 10'd1;
    assign exp_inc     = r_exp_idx + 8'd1;
    assign at_seg_pkt  = (r_exp_idx == vsps_pkg::SEG_PACKET);
    assign seg_bad     = (id_seg == 4'd0) || (id_seg > i_cfg.max_seg_num);
    assign cap_seg_upd = at_seg_pkt ? id_seg : r_cap_seg;

    // Decision and next state
    always_comb begin
        o_res.status      = vsps_pkg::ST_STORED;
        o_res.packet_slot = 8'd0;
        o_res.seg_num     = 4'd0;
        n_exp_idx         = r_exp_idx;
        n_resyncs         = r_resyncs;
        n_cap_seg         = r_cap_seg;
        priority if (bad_pkt) begin
            if (resyncs_inc >= i_cfg.max_resyncs) begin
                o_res.status = vsps_pkg::ST_GAVE_UP;
                n_exp_idx    = 8'd0;
                n_resyncs    = 10'd0;
                n_cap_seg    = 4'd0;
            end else begin
                o_res.status = vsps_pkg::ST_RESYNC;
                n_exp_idx    = 8'd0;
                n_resyncs    = resyncs_inc;
            end
        end else if (at_seg_pkt && seg_bad) begin
            o_res.status  = vsps_pkg::ST_INVALID;
            o_res.seg_num = id_seg;
            n_exp_idx     = 8'd0;
            n_resyncs     = 10'd0;
            n_cap_seg     = 4'd0;
        end else if (exp_inc >= 8'(vsps_pkg::PACKETS_PER_SEG)) begin
            o_res.status      = vsps_pkg::ST_DONE;
            o_res.packet_slot = r_exp_idx;
            o_res.seg_num     = cap_seg_upd;
            n_exp_idx         = 8'd0;
            n_resyncs         = 10'd0;
            n_cap_seg         = 4'd0;
        end else begin
            o_res.packet_slot = r_exp_idx;
            n_exp_idx         = exp_inc;
            n_cap_seg         = cap_seg_upd;
        end
    end

    // State update when a word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= 8'd0;
            r_resyncs <= 10'd0;
            r_cap_seg <= 4'd0;
        end else if (i_advance) begin
            r_exp_idx <= n_exp_idx;
            r_resyncs <= n_resyncs;
            r_cap_seg <= n_cap_seg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/video_spi_segment_packet_sync.sv =====
// Throughput: one packet header per cycle unless the result side stalls;
// an accepted word waits in the input register, and its decision goes to
// the result register; the two stages advance when the result side is free.
// Reset: synchronous active low; clears sync state, pipeline valids, and
// loads register defaults (max_resyncs 750, segment number limit 4).
// ----------------------------------------------------------------------------
// video_spi_segment_packet_sync
// Tracks packet order within video SPI segments and reports per-packet status.
// ----------------------------------------------------------------------------
`default_nettype none

module video_spi_segment_packet_sync (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Packet header stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [7:0] header_id_byte, [15:8] packet_number_byte
    input  wire logic        s_axis_tuser,  // [0] transfer_failed
    // Result stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // [7:0] packet_slot, [11:8] seg_num, zero pad
    output logic      [2:0]  m_axis_tuser   // [2:0] status
);

    vsps_pkg::t_cfg     cfg;
    vsps_pkg::t_pkt_in  r_in;
    vsps_pkg::t_pkt_res r_out;
    vsps_pkg::t_pkt_res step_res;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               advance;
    logic               out_free;

    vsps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline flow control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.header_id_byte     <= s_axis_tdata[7:0];
            r_in.packet_number_byte <= s_axis_tdata[15:8];
            r_in.transfer_failed    <= s_axis_tuser;
        end
    end

    vsps_sync_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pkt     (r_in),
        .i_cfg     (cfg),
        .o_res     (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.seg_num, r_out.packet_slot};
    assign m_axis_tuser  = r_out.status;

`ifndef SYNTH
    // Segment done always carries the last slot of the segment
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == vsps_pkg::ST_DONE)
            |-> (r_out.packet_slot == vsps_pkg::SEG_LAST_SLOT))
        else $error("segment done with wrong slot");

    // Resync and give-up words carry no slot and no segment number
    a_resync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == vsps_pkg::ST_RESYNC ||
                         r_out.status == vsps_pkg::ST_GAVE_UP))
            |-> (r_out.packet_slot == 8'd0 && r_out.seg_num == 4'd0))
        else $error("resync word with nonzero payload");

    // Stored words carry no segment number
    a_stored_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == vsps_pkg::ST_STORED)
            |-> (r_out.seg_num == 4'd0))
        else $error("stored word with segment number");

    // A stalled result word holds until it is taken
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("result word changed under stall");
`endif

endmodule

`default_nettype wire
